/* sv/rscd_pkg.sv */
// Shared types, request codes and chain constants for the relay shift chain driver.
// Used by relay_shift_chain_driver_top; depends on nothing else.
package rscd_pkg;

  localparam int CHAIN_BITS = 16;
  localparam int BC_W = $clog2(CHAIN_BITS + 1);
  localparam int EXT_W = (CHAIN_BITS > 16) ? CHAIN_BITS : 16;

  localparam logic [1:0] REQ_ENERGIZE = 2'd0;
  localparam logic [1:0] REQ_RELEASE  = 2'd1;
  localparam logic [1:0] REQ_UPDATE   = 2'd2;
  localparam logic [1:0] REQ_TICK     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] bit_mask;
  } rscd_in_t;

  typedef struct packed {
    logic        ser_data;
    logic        shift_clk;
    logic        latch_clk;
    logic        busy_res;
    logic [15:0] latched_word;
  } rscd_out_t;

  // Serial bit for position idx of a frame, MSB first; positions above bit 15 send 1.
  function automatic logic frame_bit(input logic [15:0] word, input logic [BC_W-1:0] idx);
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] sh;
    int               p;
    ext = {EXT_W{1'b1}};
    ext[15:0] = word;
    p = CHAIN_BITS - 1 - int'(idx);
    sh = ext >> p;
    return sh[0];
  endfunction

  // Low 16 bits of the chain's parallel outputs, zero-extended for short chains.
  function automatic logic [15:0] low_word(input logic [CHAIN_BITS-1:0] img);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < CHAIN_BITS; i++) begin
      if (i < 16) r[i] = img[i];
    end
    return r;
  endfunction

endpackage

/* sv/relay_shift_chain_driver_top.sv */
// Top level of the relay shift chain driver: command decode, pin sequencer and APB registers.
// Depends on rscd_pkg for the request and result types and the chain constants.
//
// Usage: each request on the input channel (in_valid/in_ready, in_data) is an energize
// mask, a release mask, an update request or a tick. Every accepted request yields exactly
// one result on the output channel (out_valid/out_ready, out_data) carrying the serial pin
// levels, the busy flag and the word latched on the chain after that request.
// A request's result is registered and offered in the cycle after it is taken. Throughput
// is one request per cycle while results are taken; the whole update of the sequencer state
// is one pass of logic from the accepted request to the result register, so nothing iterates.
// When the receiver stalls, the result register holds its contents and in_ready falls,
// so no request is taken until the waiting result has been collected; in the cycle the
// result is taken a new request may enter.
// Pin phases only advance on tick requests; a frame takes 2*CHAIN_BITS+2 phases of
// phase_ticks ticks each; break-before-make adds release_hold_ticks ticks and a second frame.
// Synchronous reset (rst_n low) restores the register defaults (hold 200, phase 1), sets
// the wanted and applied words to 0x0FFF, shows all relays off and empties the result.
// The user writes configuration via the APB port while idle (unchecked); pready is tied high.
module relay_shift_chain_driver_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rscd_pkg::rscd_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rscd_pkg::rscd_out_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Sequencer phase codes.
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_START = 4'd1;
  localparam logic [3:0] PH_DATA  = 4'd2;
  localparam logic [3:0] PH_CLKH  = 4'd3;
  localparam logic [3:0] PH_LATCH = 4'd4;
  localparam logic [3:0] PH_HOLD  = 4'd5;

  localparam int CB = rscd_pkg::CHAIN_BITS;
  localparam int BW = rscd_pkg::BC_W;

  // Configuration registers.
  logic [15:0] hold_cfg_r;
  logic [7:0]  phase_cfg_r;

  // Sequencer state.
  logic [15:0]   wanted_r, wanted_nxt;
  logic [15:0]   applied_r, applied_nxt;
  logic [15:0]   final_r, final_nxt;
  logic [15:0]   shift_r, shift_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic [3:0]    phase_r, phase_nxt;
  logic [15:0]   hold_r, hold_nxt;
  logic [7:0]    pcount_r, pcount_nxt;
  logic          pend_r, pend_nxt;
  logic [CB-1:0] stage_r, stage_nxt;
  logic [CB-1:0] image_r, image_nxt;
  logic [2:0]    pins_r, pins_nxt;

  // Result register.
  logic                out_valid_r;
  rscd_pkg::rscd_out_t out_data_r;

  logic in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // APB side: writes land at the access edge, reads are combinational.
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2]) begin
      prdata = {24'd0, phase_cfg_r};
    end else begin
      prdata = {16'd0, hold_cfg_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cfg_r  <= 16'd200;
      phase_cfg_r <= 8'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        phase_cfg_r <= pwdata[7:0];
      end else begin
        hold_cfg_r <= pwdata[15:0];
      end
    end
  end

  // Next state for one accepted request.
  always_comb begin
    logic [15:0]   rel;
    logic [15:0]   hdec;
    logic [7:0]    lim;
    logic [7:0]    pc;
    logic [BW-1:0] bc;
    wanted_nxt = wanted_r;
    applied_nxt = applied_r;
    final_nxt = final_r;
    shift_nxt = shift_r;
    bit_nxt = bit_r;
    phase_nxt = phase_r;
    hold_nxt = hold_r;
    pcount_nxt = pcount_r;
    pend_nxt = pend_r;
    stage_nxt = stage_r;
    image_nxt = image_r;
    pins_nxt = pins_r;
    rel = applied_r | wanted_r;
    hdec = hold_r - {15'd0, (hold_r != 16'd0)};
    lim = (phase_cfg_r == 8'd0) ? 8'd1 : phase_cfg_r;
    pc = pcount_r + 8'd1;
    bc = bit_r + BW'(1);
    if (in_fire) begin
      case (in_data.req_type)
        rscd_pkg::REQ_ENERGIZE: begin
          wanted_nxt = wanted_r & ~in_data.bit_mask;
        end
        rscd_pkg::REQ_RELEASE: begin
          wanted_nxt = wanted_r | in_data.bit_mask;
        end
        rscd_pkg::REQ_UPDATE: begin
          if (phase_r == PH_IDLE && applied_r != wanted_r) begin
            applied_nxt = wanted_r;
            final_nxt = wanted_r;
            pend_nxt = (rel != wanted_r);
            shift_nxt = rel;
            bit_nxt = '0;
            pcount_nxt = 8'd0;
            phase_nxt = PH_START;
            pins_nxt = {2'b00, pins_r[0]};
          end
        end
        default: begin
          if (phase_r == PH_HOLD) begin
            hold_nxt = hdec;
            if (hdec == 16'd0) begin
              shift_nxt = final_r;
              bit_nxt = '0;
              pcount_nxt = 8'd0;
              phase_nxt = PH_START;
              pins_nxt = {2'b00, pins_r[0]};
            end
          end else if (phase_r != PH_IDLE) begin
            if (pc >= lim) begin
              pcount_nxt = 8'd0;
              case (phase_r)
                PH_START: begin
                  phase_nxt = PH_DATA;
                  pins_nxt = {2'b00, rscd_pkg::frame_bit(shift_r, '0)};
                end
                PH_DATA: begin
                  phase_nxt = PH_CLKH;
                  pins_nxt = pins_r | 3'b010;
                  stage_nxt = {stage_r[CB-2:0], pins_r[0]};
                end
                PH_CLKH: begin
                  bit_nxt = bc;
                  if (bc < BW'(CB)) begin
                    phase_nxt = PH_DATA;
                    pins_nxt = {2'b00, rscd_pkg::frame_bit(shift_r, bc)};
                  end else begin
                    phase_nxt = PH_LATCH;
                    pins_nxt = {2'b10, pins_r[0]};
                    image_nxt = stage_r;
                  end
                end
                PH_LATCH: begin
                  pins_nxt = {2'b00, pins_r[0]};
                  if (pend_r) begin
                    pend_nxt = 1'b0;
                    if (hold_cfg_r == 16'd0) begin
                      shift_nxt = final_r;
                      bit_nxt = '0;
                      phase_nxt = PH_START;
                    end else begin
                      hold_nxt = hold_cfg_r;
                      phase_nxt = PH_HOLD;
                    end
                  end else begin
                    phase_nxt = PH_IDLE;
                  end
                end
                default: begin
                  phase_nxt = PH_IDLE;
                end
              endcase
            end else begin
              pcount_nxt = pc;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= 16'h0FFF;
      applied_r <= 16'h0FFF;
      final_r <= 16'd0;
      shift_r <= 16'd0;
      bit_r <= '0;
      phase_r <= PH_IDLE;
      hold_r <= 16'd0;
      pcount_r <= 8'd0;
      pend_r <= 1'b0;
      stage_r <= '1;
      image_r <= '1;
      pins_r <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      wanted_r <= wanted_nxt;
      applied_r <= applied_nxt;
      final_r <= final_nxt;
      shift_r <= shift_nxt;
      bit_r <= bit_nxt;
      phase_r <= phase_nxt;
      hold_r <= hold_nxt;
      pcount_r <= pcount_nxt;
      pend_r <= pend_nxt;
      stage_r <= stage_nxt;
      image_r <= image_nxt;
      pins_r <= pins_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The result reflects the state left by the request just taken.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.ser_data <= pins_nxt[0];
      out_data_r.shift_clk <= pins_nxt[1];
      out_data_r.latch_clk <= pins_nxt[2];
      out_data_r.busy_res <= (phase_nxt != PH_IDLE);
      out_data_r.latched_word <= rscd_pkg::low_word(image_nxt);
    end
  end

`ifndef SYNTHESIS
  // Both serial clocks rest low whenever the sequencer is idle.
  a_idle_clocks_low: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (pins_r[2:1] == 2'b00))
    else $error("serial clocks high while idle");

  // The latch pin is high only in the latch phase.
  a_latch_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pins_r[2] |-> (phase_r == PH_LATCH))
    else $error("latch pin high outside latch phase");

  // A hold never sits with an exhausted counter.
  a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HOLD) |-> (hold_r != 16'd0))
    else $error("hold phase with zero count");

  // An update taken while busy leaves the captured words alone.
  a_busy_update_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.req_type == rscd_pkg::REQ_UPDATE && phase_r != PH_IDLE)
      |=> (applied_r == $past(applied_r) && final_r == $past(final_r)))
    else $error("update while busy changed the frame words");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for relay_shift_chain_driver_top: directed requests, then random ones.
// Depends on rscd_pkg for the request and result types; it carries its own model of the sequencer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rscd_pkg::*;

  // Register indexes of the configuration port.
  localparam int REG_HOLD  = 0;
  localparam int REG_PHASE = 1;

  // Settings for the random phases: release hold, phase length and number of requests.
  localparam int N_SETS = 8;
  localparam int HOLD_SET  [N_SETS] = '{0, 1, 5, 0, 2, 9, 20, 3};
  localparam int PHASE_SET [N_SETS] = '{1, 1, 2, 0, 3, 2, 1, 1};
  localparam int COUNT_SET [N_SETS] = '{50, 40, 40, 30, 40, 30, 40, 30};

  // One row of the directed table.  Where typed is set, res is the result written out by
  // hand; otherwise the row is checked against the sequencer model.
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] mask;
    logic        typed;
    logic [19:0] res;    // {ser, shift clock, latch clock, busy, latched word}
  } stim_row_t;

  localparam int N_ROWS = 22;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // Straight after reset: idle, all relays off.
    '{REQ_TICK,     16'h0000, 1'b1, {4'b0000, 16'hFFFF}},
    // Update with equal words is ignored; its mask is ignored too.
    '{REQ_UPDATE,   16'hFFFF, 1'b1, {4'b0000, 16'hFFFF}},
    '{REQ_ENERGIZE, 16'hFFFF, 1'b1, {4'b0000, 16'hFFFF}},
    '{REQ_RELEASE,  16'h8000, 1'b1, {4'b0000, 16'hFFFF}},
    '{REQ_ENERGIZE, 16'h8000, 1'b1, {4'b0000, 16'hFFFF}},
    // Break-before-make update: the release frame starts, busy rises.
    '{REQ_UPDATE,   16'h0000, 1'b1, {4'b0001, 16'hFFFF}},
    // A second update while busy is ignored.
    '{REQ_UPDATE,   16'h0000, 1'b1, {4'b0001, 16'hFFFF}},
    '{REQ_TICK,     16'h0000, 1'b1, {4'b0001, 16'hFFFF}},
    '{REQ_TICK,     16'hFFFF, 1'b1, {4'b0101, 16'hFFFF}},
    // A command while busy changes the wanted word only.
    '{REQ_RELEASE,  16'h0001, 1'b1, {4'b0101, 16'hFFFF}},
    '{REQ_TICK,     16'h0000, 1'b0, 20'h0},
    '{REQ_ENERGIZE, 16'h00F0, 1'b0, 20'h0},
    '{REQ_TICK,     16'h0000, 1'b0, 20'h0},
    '{REQ_TICK,     16'h0000, 1'b0, 20'h0},
    '{REQ_TICK,     16'h0000, 1'b0, 20'h0},
    '{REQ_TICK,     16'h0000, 1'b0, 20'h0},
    '{REQ_UPDATE,   16'h0000, 1'b0, 20'h0},
    '{REQ_TICK,     16'h0000, 1'b0, 20'h0},
    '{REQ_TICK,     16'h0000, 1'b0, 20'h0},
    '{REQ_TICK,     16'h0000, 1'b0, 20'h0},
    '{REQ_RELEASE,  16'hFFFF, 1'b0, 20'h0},
    '{REQ_TICK,     16'h0000, 1'b0, 20'h0}
  };

  typedef enum logic [2:0] {SQ_IDLE, SQ_START, SQ_DATA, SQ_CLKH, SQ_LATCH, SQ_HOLD} seq_ph_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  rscd_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  rscd_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  relay_shift_chain_driver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Pin levels and latched words still owed by the block, oldest first.
  rscd_out_t pending_pins[$];
  int        mismatches = 0;

  // Largest idle gaps of the sender and the receiver; zero gives a stretch at full rate.
  int tx_gap_max = 11;
  int rx_gap_max = 11;

  // ---------------------------------------------------------------------------------------
  // Model of the pin sequencer.  Its state is advanced once per accepted request, in the
  // order the block accepts them.
  // ---------------------------------------------------------------------------------------
  logic [15:0]           cfg_hold;
  logic [7:0]            cfg_phase;
  logic [15:0]           want_w;      // word the commands have built up
  logic [15:0]           live_w;      // word the last accepted update committed to
  logic [15:0]           tail_w;      // word of the final frame of an update
  logic [15:0]           frame_w;     // word being shifted out
  logic                  tail_due;
  seq_ph_t               sq;
  int                    bit_idx;
  int                    hold_left;
  int                    ph_cnt;
  logic [CHAIN_BITS-1:0] stage_q;     // shift stage of the chain
  logic [CHAIN_BITS-1:0] image_q;     // parallel outputs of the chain
  logic                  pin_d, pin_s, pin_l;

  function automatic void chain_reset();
    cfg_hold  = 16'd200;
    cfg_phase = 8'd1;
    want_w    = 16'h0FFF;
    live_w    = 16'h0FFF;
    tail_w    = '0;
    frame_w   = '0;
    tail_due  = 1'b0;
    sq        = SQ_IDLE;
    bit_idx   = 0;
    hold_left = 0;
    ph_cnt    = 0;
    stage_q   = '1;
    image_q   = '1;
    {pin_d, pin_s, pin_l} = 3'b000;
  endfunction

  // Bit sent at position idx of a frame, MSB first; chain positions above bit 15 get a 1.
  function automatic logic serial_bit(input logic [15:0] word, input int idx);
    logic [63:0] ext;
    ext = {48'hFFFF_FFFF_FFFF, word};
    return ext[CHAIN_BITS - 1 - idx];
  endfunction

  function automatic void start_frame(input logic [15:0] word);
    frame_w = word;
    bit_idx = 0;
    ph_cnt  = 0;
    sq      = SQ_START;
    pin_s   = 1'b0;
    pin_l   = 1'b0;
  endfunction

  function automatic void next_phase();
    case (sq)
      SQ_START: begin
        sq    = SQ_DATA;
        pin_d = serial_bit(frame_w, 0);
        pin_s = 1'b0;
        pin_l = 1'b0;
      end
      SQ_DATA: begin
        sq      = SQ_CLKH;
        pin_s   = 1'b1;
        stage_q = {stage_q[CHAIN_BITS-2:0], pin_d};
      end
      SQ_CLKH: begin
        bit_idx++;
        pin_s = 1'b0;
        if (bit_idx < CHAIN_BITS) begin
          sq    = SQ_DATA;
          pin_d = serial_bit(frame_w, bit_idx);
          pin_l = 1'b0;
        end else begin
          sq      = SQ_LATCH;
          pin_l   = 1'b1;
          image_q = stage_q;
        end
      end
      SQ_LATCH: begin
        pin_s = 1'b0;
        pin_l = 1'b0;
        if (tail_due) begin
          tail_due = 1'b0;
          if (cfg_hold == 16'd0) begin
            start_frame(tail_w);
          end else begin
            hold_left = cfg_hold;
            sq        = SQ_HOLD;
          end
        end else begin
          sq = SQ_IDLE;
        end
      end
      default: sq = SQ_IDLE;
    endcase
  endfunction

  function automatic void tick_chain();
    int lim;
    if (sq == SQ_IDLE) return;
    if (sq == SQ_HOLD) begin
      if (hold_left > 0) hold_left--;
      if (hold_left == 0) start_frame(tail_w);
      return;
    end
    lim = (cfg_phase == 8'd0) ? 1 : int'(cfg_phase);
    ph_cnt++;
    if (ph_cnt >= lim) begin
      ph_cnt = 0;
      next_phase();
    end
  endfunction

  // Applies one request to the model and returns the pin levels that follow it.
  function automatic rscd_out_t chain_next(input rscd_in_t r);
    rscd_out_t   res;
    logic [15:0] rel;
    logic [63:0] wide;
    case (r.req_type)
      REQ_ENERGIZE: want_w = want_w & ~r.bit_mask;
      REQ_RELEASE:  want_w = want_w | r.bit_mask;
      REQ_UPDATE: begin
        if (sq == SQ_IDLE && live_w != want_w) begin
          // Dropped relays open first: the release frame carries the OR of both words.
          rel      = live_w | want_w;
          live_w   = want_w;
          tail_w   = want_w;
          tail_due = (rel != want_w);
          start_frame(rel);
        end
      end
      default: tick_chain();
    endcase
    wide = '0;
    wide[CHAIN_BITS-1:0] = image_q;
    res.ser_data     = pin_d;
    res.shift_clk    = pin_s;
    res.latch_clk    = pin_l;
    res.busy_res     = (sq != SQ_IDLE);
    res.latched_word = wide[15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Clock, run limit and the receiver.
  // ---------------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A correct run finishes well within this limit; a run that reaches it fails.
  initial begin
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // The receiver stalls a random number of cycles before taking each result.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Signals are sampled at the clock edge, before any of this edge's updates land.
  always @(posedge clk) begin : result_check
    rscd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pins.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing, actual %h",
                 $time, out_data);
        mismatches++;
      end else begin
        want = pending_pins.pop_front();
        check_field("ser_data", 16'(want.ser_data), 16'(out_data.ser_data));
        check_field("shift_clk", 16'(want.shift_clk), 16'(out_data.shift_clk));
        check_field("latch_clk", 16'(want.latch_clk), 16'(out_data.latch_clk));
        check_field("busy_res", 16'(want.busy_res), 16'(out_data.busy_res));
        check_field("latched_word", want.latched_word, out_data.latched_word);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender side.  Each call starts just after the clock rises.  in_valid is left high after
  // an acceptance, so that a request that follows without a gap keeps it high; anything that
  // lets time pass without sending must lower it first.
  // ---------------------------------------------------------------------------------------
  task automatic send_req(input rscd_in_t r, input logic typed, input rscd_out_t typed_res);
    int        gap;
    rscd_out_t predicted;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    // Accepted at this edge: the model moves on and the expectation is queued.
    predicted = chain_next(r);
    pending_pins.push_back(typed ? typed_res : predicted);
  endtask

  // Holds the sender back until every request has produced its result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pins.size() != 0);
  endtask

  // Writes a register with a setup and an access cycle, then reads it back the same way.
  task automatic reg_write(input int idx, input logic [31:0] value);
    logic [31:0] want;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    want = (idx == REG_HOLD) ? (value & 32'h0000_FFFF) : (value & 32'h0000_00FF);
    if (prdata !== want) begin
      $display("%0t ns: readback of register %0d, expected %h, actual %h",
               $time, idx, want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_HOLD) cfg_hold = value[15:0];
    else cfg_phase = value[7:0];
  endtask

  function automatic logic [15:0] pick_mask();
    if ($urandom_range(0, 3) == 0) return 16'h0001 << $urandom_range(0, 15);
    return 16'($urandom);
  endfunction

  // Ticks the sequencer back to idle so that the registers may be changed.  Long holds and
  // slow phases run at full rate so that the run stays short.
  task automatic settle_chain();
    rscd_in_t r;
    int       keep_tx, keep_rx;
    keep_tx = tx_gap_max;
    keep_rx = rx_gap_max;
    if (cfg_hold > 16'd300 || cfg_phase > 8'd4) begin
      tx_gap_max = 0;
      rx_gap_max = 0;
    end
    while (sq != SQ_IDLE) begin
      r.req_type = REQ_TICK;
      r.bit_mask = 16'($urandom);
      send_req(r, 1'b0, '0);
    end
    tx_gap_max = keep_tx;
    rx_gap_max = keep_rx;
  endtask

  // Mostly ticks, so that updates run through whole frames and holds, with commands and
  // updates, some of them while busy, mixed in.
  task automatic random_burst(input int n);
    rscd_in_t r;
    int       k;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 || $urandom_range(0, 63) == 0) wait_drained();
      k = $urandom_range(0, 99);
      if (k < 8) r.req_type = REQ_ENERGIZE;
      else if (k < 16) r.req_type = REQ_RELEASE;
      else if (k < 24) r.req_type = REQ_UPDATE;
      else r.req_type = REQ_TICK;
      r.bit_mask = (k < 16) ? pick_mask() : 16'($urandom);
      send_req(r, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then one random phase per register setting.
  // Every register change waits for an idle sequencer and an empty result queue.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    rscd_in_t r;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    chain_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      r.req_type = DIRECTED[i].op;
      r.bit_mask = DIRECTED[i].mask;
      send_req(r, DIRECTED[i].typed, rscd_out_t'(DIRECTED[i].res));
    end

    for (int p = 0; p < N_SETS; p++) begin
      settle_chain();
      // Largest values first, so that the readback covers the full register widths.
      if (p == 0) begin
        reg_write(REG_HOLD, 32'hFFFF_FFFF);
        reg_write(REG_PHASE, 32'hFFFF_FFFF);
      end
      reg_write(REG_HOLD, 32'(HOLD_SET[p]));
      reg_write(REG_PHASE, 32'(PHASE_SET[p]));
      // The last phase runs with no idling on either side.
      if (p == N_SETS - 1) begin
        tx_gap_max = 0;
        rx_gap_max = 0;
      end
      random_burst(COUNT_SET[p]);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* relay_shift_chain_driver_top.f */
sv/rscd_pkg.sv
sv/relay_shift_chain_driver_top.sv
test/tb_top.sv
